@@ rtl/fpp_pkg.sv @@
// fpp_pkg: shared types and constants for the farthest point pair block
// no dependencies; used by farthest_point_pair
package fpp_pkg;

    // width of the index fields on the result stream
    localparam int OUT_IDX_W = 4;

    // sequencer states of the top level
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } fpp_state_t;

endpackage

@@ rtl/fpp_point_store.sv @@
// fpp_point_store: single-port-write, single-port-read point memory
// read data registered; no package dependency
module fpp_point_store #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] store_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/fpp_dist_unit.sv @@
// fpp_dist_unit: three-stage squared distance pipeline (abs diff, square, sum)
// no package dependency; fed by the point store read data in the top level
module fpp_dist_unit #(
    parameter int COORD_BITS = 16,
    parameter int IDX_W      = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [IDX_W-1:0]          in_idx,
    input  logic [2*COORD_BITS-1:0]   stored_point,
    input  logic signed [COORD_BITS-1:0] new_x,
    input  logic signed [COORD_BITS-1:0] new_y,
    output logic                      out_valid,
    output logic [IDX_W-1:0]          out_idx,
    output logic [2*COORD_BITS:0]     out_dist,
    output logic                      busy
);

    localparam int C = COORD_BITS;

    logic signed [C-1:0] sx;
    logic signed [C-1:0] sy;
    logic signed [C:0]   diff_x;
    logic signed [C:0]   diff_y;
    logic        [C:0]   mag_x;
    logic        [C:0]   mag_y;

    logic                v2_reg;
    logic                v3_reg;
    logic                v4_reg;
    logic [IDX_W-1:0]    i2_reg;
    logic [IDX_W-1:0]    i3_reg;
    logic [IDX_W-1:0]    i4_reg;
    logic [C-1:0]        dx_reg;
    logic [C-1:0]        dy_reg;
    logic [2*C-1:0]      sqx_reg;
    logic [2*C-1:0]      sqy_reg;
    logic [2*C:0]        sum_reg;

    // absolute coordinate differences, magnitude fits in C bits
    always_comb
    begin
        sx     = stored_point[C-1:0];
        sy     = stored_point[2*C-1:C];
        diff_x = {sx[C-1], sx} - {new_x[C-1], new_x};
        diff_y = {sy[C-1], sy} - {new_y[C-1], new_y};
        mag_x  = diff_x[C] ? (~diff_x + 1'b1) : diff_x;
        mag_y  = diff_y[C] ? (~diff_y + 1'b1) : diff_y;
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= in_valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        dx_reg  <= mag_x[C-1:0];
        dy_reg  <= mag_y[C-1:0];
        i2_reg  <= in_idx;
        sqx_reg <= (2*C)'(dx_reg) * (2*C)'(dx_reg);
        sqy_reg <= (2*C)'(dy_reg) * (2*C)'(dy_reg);
        i3_reg  <= i2_reg;
        sum_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        i4_reg  <= i3_reg;
    end

    assign out_valid = v4_reg;
    assign out_idx   = i4_reg;
    assign out_dist  = sum_reg;
    assign busy      = v2_reg | v3_reg | v4_reg;

endmodule

@@ rtl/farthest_point_pair.sv @@
// farthest_point_pair: top level, sequencer and best-pair tracking
// depends on fpp_pkg, fpp_point_store, fpp_dist_unit
//
// Usage: points arrive on the s_ stream, one request per point, x in the low
// COORD_BITS of s_tdata and y above it; s_tlast marks the final point of a
// set. The first MAX_POINTS points are stored, later ones are dropped but
// their s_tlast still closes the set. On the closing point one request
// leaves on the m_ stream with the indices (i, j) of the pair of greatest
// squared distance, ties going to the lowest i; fewer than two points gives
// (0, 0). The point count and best pair then return to their reset values.
// Sequence: a point arriving when j points are stored is compared with each of
// them through one read of the point memory and one distance pipeline
// (j from 1 to MAX_POINTS - 1), and no new point is taken until the scan,
// drain and finish states are done; a dropped point or the first point
// goes straight to the finish state. With the output register free, the
// result is loaded in the finish state that ends the closing point's work.
// Reset clears the point count and best pair; memory contents are not
// cleared. The result sits in an output register: new points are taken while
// it waits; a closing point whose result finds that register still full
// waits until the receiver takes the previous result.
module farthest_point_pair #(
    parameter int MAX_POINTS = 16,
    parameter int COORD_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    // s_tdata fields from bit 0: point_x, point_y, zero fill to bytes
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    input  logic                                   s_tlast,
    // m_tdata fields from bit 0: first_index[3:0], second_index[7:4]
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [7:0]                             m_tdata
);

    localparam int C      = COORD_BITS;
    localparam int IDX_W  = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIST_W = 2 * C + 1;
    localparam int OW     = fpp_pkg::OUT_IDX_W;

    fpp_pkg::fpp_state_t state_reg;
    fpp_pkg::fpp_state_t state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  j_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              last_reg;
    logic signed [C-1:0] px_reg;
    logic signed [C-1:0] py_reg;
    logic [IDX_W-1:0]  best_first_reg;
    logic [IDX_W-1:0]  best_second_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic              v1_reg;
    logic [IDX_W-1:0]  i1_reg;
    logic              m_tvalid_reg;
    logic [OW-1:0]     out_first_reg;
    logic [OW-1:0]     out_second_reg;

    logic              accept;
    logic              store_new;
    logic              rd_en;
    logic              issue_last;
    logic              out_free;
    logic              result_load;
    logic [2*C-1:0]    rd_data;
    logic              dist_valid;
    logic [IDX_W-1:0]  dist_idx;
    logic [DIST_W-1:0] dist_val;
    logic              dist_busy;
    logic              take_pair;
    logic [IDX_W+OW-1:0] first_ext;
    logic [IDX_W+OW-1:0] second_ext;

    assign accept     = s_tvalid & s_tready;
    assign store_new  = accept && (count_reg < CNT_W'(MAX_POINTS));
    assign issue_last = (rd_idx_reg == j_reg - IDX_W'(1));
    assign out_free   = !m_tvalid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fpp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (store_new && (count_reg != CNT_W'(0)))
                        state_next = fpp_pkg::ST_SCAN;
                    else
                        state_next = fpp_pkg::ST_FINISH;
                end
            end
            fpp_pkg::ST_SCAN:
            begin
                if (issue_last)
                    state_next = fpp_pkg::ST_DRAIN;
            end
            fpp_pkg::ST_DRAIN:
            begin
                if (!v1_reg && !dist_busy)
                    state_next = fpp_pkg::ST_FINISH;
            end
            fpp_pkg::ST_FINISH:
            begin
                if (!last_reg || out_free)
                    state_next = fpp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fpp_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready    = 1'b0;
        rd_en       = 1'b0;
        result_load = 1'b0;
        case (state_reg)
            fpp_pkg::ST_IDLE:   s_tready    = 1'b1;
            fpp_pkg::ST_SCAN:   rd_en       = 1'b1;
            fpp_pkg::ST_DRAIN:  rd_en       = 1'b0;
            fpp_pkg::ST_FINISH: result_load = last_reg && out_free;
            default:            rd_en       = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fpp_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // point memory
    fpp_point_store #(
        .DEPTH  (MAX_POINTS),
        .ADDR_W (IDX_W),
        .DATA_W (2 * C)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_new),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (s_tdata[2*C-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    // distance pipeline
    fpp_dist_unit #(
        .COORD_BITS (C),
        .IDX_W      (IDX_W)
    ) u_dist (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (v1_reg),
        .in_idx       (i1_reg),
        .stored_point (rd_data),
        .new_x        (px_reg),
        .new_y        (py_reg),
        .out_valid    (dist_valid),
        .out_idx      (dist_idx),
        .out_dist     (dist_val),
        .busy         (dist_busy)
    );

    // best pair update rule
    assign take_pair = dist_valid &&
                       ((j_reg == IDX_W'(1)) || (dist_val > best_dist_reg) ||
                        ((dist_val == best_dist_reg) && (dist_idx < best_first_reg)));

    // read issue tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= rd_en;
    end

    always_ff @(posedge clk)
    begin
        i1_reg <= rd_idx_reg;
        if (accept)
        begin
            rd_idx_reg <= '0;
            j_reg      <= count_reg[IDX_W-1:0];
            px_reg     <= s_tdata[C-1:0];
            py_reg     <= s_tdata[2*C-1:C];
        end
        else if (rd_en)
        begin
            rd_idx_reg <= rd_idx_reg + IDX_W'(1);
        end
    end

    // set state: point count, best pair, closing flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            last_reg        <= 1'b0;
            best_first_reg  <= '0;
            best_second_reg <= '0;
            best_dist_reg   <= '0;
        end
        else
        begin
            if (accept)
                last_reg <= s_tlast;
            if (store_new)
                count_reg <= count_reg + CNT_W'(1);
            if (take_pair)
            begin
                best_dist_reg   <= dist_val;
                best_first_reg  <= dist_idx;
                best_second_reg <= j_reg;
            end
            if (result_load)
            begin
                count_reg       <= '0;
                best_first_reg  <= '0;
                best_second_reg <= '0;
                best_dist_reg   <= '0;
            end
        end
    end

    // index fields masked to the result width
    assign first_ext  = {{OW{1'b0}}, best_first_reg};
    assign second_ext = {{OW{1'b0}}, best_second_reg};

    // result output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (result_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            if (count_reg >= CNT_W'(2))
            begin
                out_first_reg  <= first_ext[OW-1:0];
                out_second_reg <= second_ext[OW-1:0];
            end
            else
            begin
                out_first_reg  <= '0;
                out_second_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_second_reg, out_first_reg};

endmodule
